### sv/bgsff_pkg.sv
// ----------------------------------------------------------------------------
// bgsff_pkg
// Shared codes and types of the bit-array store: operation modes, the plan
// kinds that the decode stage hands to the sequencer, and the plan struct.
// ----------------------------------------------------------------------------
package bgsff_pkg;

  // Operation modes on the mode port
  localparam logic [2:0] MODE_GET   = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_FILL  = 3'd2;
  localparam logic [2:0] MODE_FIRST = 3'd3;
  localparam logic [2:0] MODE_LAST  = 3'd4;

  // Work that the sequencer runs for one word
  localparam logic [2:0] K_NONE  = 3'd0;  // answer at once, no store access
  localparam logic [2:0] K_GET   = 3'd1;
  localparam logic [2:0] K_SET   = 3'd2;
  localparam logic [2:0] K_FILL  = 3'd3;
  localparam logic [2:0] K_FIRST = 3'd4;
  localparam logic [2:0] K_LAST  = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic       val;   // bit value to write or to look for
    logic       miss;  // immediate answer is -1 rather than 0
  } plan_ctl_t;

endpackage

### sv/bgsff_ram.sv
// ----------------------------------------------------------------------------
// bgsff_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bgsff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/bgsff_plan.sv
// ----------------------------------------------------------------------------
// bgsff_plan
// Decode stage: wraps negative positions, clamps the range to the used
// length and registers the bit range [lo,hi) plus the first and last word
// that the sequencer has to visit.
// ----------------------------------------------------------------------------
module bgsff_plan #(
  parameter int MAX_BITS = 4096,
  parameter int WORD_BITS = 64,
  localparam int BW = $clog2(MAX_BITS),
  localparam int NW = BW + 1,
  localparam int LB = $clog2(WORD_BITS),
  localparam int WW = BW - LB
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [2:0]              mode,
  input  logic signed [12:0]      position,
  input  logic signed [13:0]      end_position,
  input  logic                    bit_value,
  input  logic [9:0]              length_bytes,
  output bgsff_pkg::plan_ctl_t    ctl,
  output logic [NW-1:0]           lo,
  output logic [NW-1:0]           hi,
  output logic [WW-1:0]           first_word,
  output logic [WW-1:0]           last_word
);
  import bgsff_pkg::*;

  localparam int CW = (NW > 13) ? NW : 13;
  localparam int SW = CW + 2;

  logic [CW-1:0]        len8;
  logic [CW-1:0]        nfull;
  logic signed [SW-1:0] ns, ps, es, pw, ew, ec, pf, pl, lo_s, hi_s;
  logic [NW-1:0]        lo_c, hi_c, hm1;
  logic [WW-1:0]        first_c, last_c;
  plan_ctl_t            ctl_c;

  // Used length in bits, limited to the store size
  assign len8  = CW'({length_bytes, 3'b000});
  assign nfull = (len8 > CW'(MAX_BITS)) ? CW'(MAX_BITS) : len8;
  assign ns    = signed'({2'b00, nfull});

  // Wrap negative positions, clamp the fill end
  assign ps = {{(SW-13){position[12]}}, position};
  assign es = {{(SW-14){end_position[13]}}, end_position};
  assign pw = ps[SW-1] ? ps + ns : ps;
  assign ew = es[SW-1] ? es + ns : es;
  assign ec = (ew > ns) ? ns : ew;
  assign pf = pw[SW-1] ? '0 : pw;
  assign pl = (pw >= ns) ? ns - SW'(1) : pw;

  // Pick the range and the kind of work
  always_comb begin
    ctl_c.kind = K_NONE;
    ctl_c.val  = bit_value;
    ctl_c.miss = 1'b0;
    lo_s       = pw;
    hi_s       = pw + SW'(1);
    case (mode)
      MODE_GET, MODE_SET: begin
        if (!pw[SW-1] && pw < ns) begin
          ctl_c.kind = (mode == MODE_GET) ? K_GET : K_SET;
        end
      end
      MODE_FILL: begin
        hi_s = ec;
        if (!pw[SW-1] && pw < ns && pw < ec) begin
          ctl_c.kind = K_FILL;
        end
      end
      MODE_FIRST: begin
        lo_s = pf;
        hi_s = ns;
        if (pf < ns) begin
          ctl_c.kind = K_FIRST;
        end else begin
          ctl_c.miss = 1'b1;
        end
      end
      MODE_LAST: begin
        lo_s = '0;
        hi_s = pl + SW'(1);
        if (!pw[SW-1] && ns > 0) begin
          ctl_c.kind = K_LAST;
        end else begin
          ctl_c.miss = 1'b1;
        end
      end
      default: begin
        ctl_c.kind = K_NONE;
      end
    endcase
  end

  assign lo_c = lo_s[NW-1:0];
  assign hi_c = hi_s[NW-1:0];
  assign hm1  = hi_c - NW'(1);

  // Scan direction decides which end of the range comes first
  always_comb begin
    if (ctl_c.kind == K_LAST) begin
      first_c = hm1[BW-1:LB];
      last_c  = lo_c[BW-1:LB];
    end else begin
      first_c = lo_c[BW-1:LB];
      last_c  = hm1[BW-1:LB];
    end
  end

  // Hold the plan for the sequencer
  always_ff @(posedge clk) begin
    if (load) begin
      ctl        <= ctl_c;
      lo         <= lo_c;
      hi         <= hi_c;
      first_word <= first_c;
      last_word  <= last_c;
    end
  end

endmodule

### sv/bitmap_get_set_fill_find.sv
// ----------------------------------------------------------------------------
// bitmap_get_set_fill_find
// Bit-array store with get, set, range fill and find first/last, held in
// one word-wide RAM that the sequencer reads, modifies and writes back.
// ----------------------------------------------------------------------------
// Usage:
//   Command: drive mode, position, end_position and bit_value with start;
//   the word is taken at a clock edge where start is high and busy is low.
//   Result: flag and found_index are valid for the one cycle in which done
//   is high; the receiver cannot hold them off.
//   Configuration: cfg_we writes cfg_wdata into length_bytes (resets to
//   512); write it only while busy is low and no command is in flight.
// Sequence: an accepted command passes the decode state (S_PLAN), which
//   answers commands without a store access itself; get and set then take
//   one bit step (S_BIT); fill and find step through the words touched or
//   scanned by the range (S_SCAN), and a find hit adds an encode step (S_ENC).
//   The RAM's single read port sets the pace: one word per cycle, over at
//   most the 64-word store.
// Reset: rst clears control state and starts a clearing pass that writes
//   zero to every RAM word (MAX_BITS/WORD_BITS words, 64 by default);
//   busy stays high until it ends.
// ----------------------------------------------------------------------------
module bitmap_get_set_fill_find #(
  parameter int MAX_BITS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [12:0] position,
  input  logic signed [13:0] end_position,
  input  logic               bit_value,
  output logic               done,
  output logic               flag,
  output logic signed [12:0] found_index,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata
);
  import bgsff_pkg::*;

  localparam int BW = $clog2(MAX_BITS);
  localparam int NW = BW + 1;
  localparam int LB = $clog2(WORD_BITS);
  localparam int WW = BW - LB;
  localparam int DEPTH = MAX_BITS / WORD_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PLAN  = 3'd2;
  localparam logic [2:0] S_BIT   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_ENC   = 3'd5;

  logic [2:0]           state, state_next;
  logic [WW-1:0]        word, word_next;
  logic [WORD_BITS-1:0] match, match_next;
  logic [9:0]           length_bytes;
  logic                 done_next, flag_next;
  logic signed [12:0]   found_next;

  plan_ctl_t            ctl;
  logic [NW-1:0]        lo, hi;
  logic [WW-1:0]        first_word, last_word;

  logic                 we;
  logic [WW-1:0]        raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic [WW:0]          wx, lo_w, hi_w;
  logic [LB-1:0]        lo_b, hi_b, enc;
  logic [WORD_BITS-1:0] lo_m, hi_m, mask, hit_vec, fill_word, set_word, onehot;
  logic                 old_bit, at_last, down;
  logic [WW-1:0]        step;
  logic                 load;

  assign busy = (state != S_IDLE);
  assign load = start && !busy;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_bytes <= 10'd512;
    end else if (cfg_we) begin
      length_bytes <= cfg_wdata;
    end
  end

  bgsff_plan #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_plan (
    .clk          (clk),
    .load         (load),
    .mode         (mode),
    .position     (position),
    .end_position (end_position),
    .bit_value    (bit_value),
    .length_bytes (length_bytes),
    .ctl          (ctl),
    .lo           (lo),
    .hi           (hi),
    .first_word   (first_word),
    .last_word    (last_word)
  );

  bgsff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (word),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Range mask of the word whose data is arriving
  assign wx   = {1'b0, word};
  assign lo_w = lo[NW-1:LB];
  assign hi_w = hi[NW-1:LB];
  assign lo_b = lo[LB-1:0];
  assign hi_b = hi[LB-1:0];

  always_comb begin
    if (wx > lo_w) begin
      lo_m = '1;
    end else if (wx == lo_w) begin
      lo_m = {WORD_BITS{1'b1}} << lo_b;
    end else begin
      lo_m = '0;
    end
    if (wx < hi_w) begin
      hi_m = '1;
    end else if (wx == hi_w) begin
      hi_m = ~({WORD_BITS{1'b1}} << hi_b);
    end else begin
      hi_m = '0;
    end
  end

  assign mask      = lo_m & hi_m;
  assign hit_vec   = (ctl.val ? rdata : ~rdata) & mask;
  assign fill_word = ctl.val ? (rdata | mask) : (rdata & ~mask);
  assign onehot    = WORD_BITS'(1) << lo_b;
  assign old_bit   = rdata[lo_b];
  assign set_word  = (rdata & ~onehot) | (ctl.val ? onehot : '0);
  assign down      = (ctl.kind == K_LAST);
  assign at_last   = (word == last_word);
  assign step      = down ? word - WW'(1) : word + WW'(1);

  // Bit position of the match: lowest going up, highest going down
  always_comb begin
    enc = '0;
    if (down) begin
      for (int k = 0; k < WORD_BITS; k++) begin
        if (match[k]) begin
          enc = LB'(k);
        end
      end
    end else begin
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
        if (match[k]) begin
          enc = LB'(k);
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    word_next  = word;
    match_next = match;
    raddr      = word;
    we         = 1'b0;
    wdata      = fill_word;
    done_next  = 1'b0;
    flag_next  = 1'b0;
    found_next = '0;
    case (state)
      S_CLEAR: begin
        we        = 1'b1;
        wdata     = '0;
        word_next = word + WW'(1);
        if (word == WW'(DEPTH - 1)) begin
          word_next  = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        raddr     = first_word;
        word_next = first_word;
        case (ctl.kind)
          K_GET, K_SET: begin
            state_next = S_BIT;
          end
          K_FILL, K_FIRST, K_LAST: begin
            state_next = S_SCAN;
          end
          default: begin
            done_next  = 1'b1;
            found_next = ctl.miss ? '1 : '0;
            state_next = S_IDLE;
          end
        endcase
      end
      S_BIT: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (ctl.kind == K_SET) begin
          we        = 1'b1;
          wdata     = set_word;
          flag_next = old_bit ^ ctl.val;
        end else begin
          flag_next = old_bit;
        end
      end
      S_SCAN: begin
        raddr     = step;
        word_next = step;
        if (ctl.kind == K_FILL) begin
          we = 1'b1;
          if (at_last) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (|hit_vec) begin
          match_next = hit_vec;
          word_next  = word;
          state_next = S_ENC;
        end else if (at_last) begin
          done_next  = 1'b1;
          found_next = '1;
          state_next = S_IDLE;
        end
      end
      S_ENC: begin
        done_next  = 1'b1;
        found_next = 13'({word, enc});
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      word  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      word  <= word_next;
      done  <= done_next;
    end
  end

  // Result and match registers
  always_ff @(posedge clk) begin
    match       <= match_next;
    flag        <= flag_next;
    found_index <= found_next;
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");

  a_accept_plan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_PLAN)
    else $error("accepted command did not reach decode");

  a_flag_found: assert property (@(posedge clk) disable iff (rst)
    (done && flag) |-> found_index == 13'sd0)
    else $error("flag set together with a found index");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_PLAN || state == S_ENC) |-> !we)
    else $error("store written outside a modify step");

endmodule

### tb/sv/tb_bitmap_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// tb_bitmap_scoreboard_pkg
// Shadow copy of the bit-array store and the queue of expected answers.
// Each accepted command updates the shadow and queues one answer. Each
// result word is compared field by field against the oldest answer.
// ----------------------------------------------------------------------------
package tb_bitmap_scoreboard_pkg;
  import bgsff_pkg::*;

  localparam int STORE_BITS  = 4096;
  localparam int STORE_BYTES = STORE_BITS / 8;

  // Mode codes that the block decodes as no-ops
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic              flag;
    logic signed [12:0] found_index;
  } answer_t;

  class bitmap_scoreboard;
    logic [STORE_BITS-1:0] shadow_bits;
    int unsigned           length_bytes;
    answer_t               answer_q[$];
    int                    errors;

    function new();
      shadow_bits  = '0;
      length_bytes = 512;
      errors       = 0;
    endfunction

    // Bits in use; an oversized length acts as the full store
    function int used_bits();
      return ((length_bytes > STORE_BYTES) ? STORE_BYTES : length_bytes) * 8;
    endfunction

    function void note_length(logic [9:0] value);
      length_bytes = value;
    endfunction

    function int outstanding();
      return answer_q.size();
    endfunction

    // Apply one accepted command to the shadow and queue its answer
    function void note_command(logic [2:0] op, logic signed [12:0] pos,
                               logic signed [13:0] endp, logic value);
      answer_t ans;
      int      n;
      int      p;
      int      e;
      int      i;
      bit      hit;
      n   = used_bits();
      p   = pos;
      e   = endp;
      hit = 1'b0;
      ans.flag        = 1'b0;
      ans.found_index = '0;
      case (op)
        MODE_GET, MODE_SET: begin
          if (p < 0) p += n;
          if (p >= 0 && p < n) begin
            if (op == MODE_GET) begin
              ans.flag = shadow_bits[p];
            end else begin
              ans.flag       = (shadow_bits[p] != value);
              shadow_bits[p] = value;
            end
          end
        end
        MODE_FILL: begin
          if (p < 0) p += n;
          if (e < 0) e += n;
          if (e > n) e = n;
          if (p >= 0 && p < n && p < e) begin
            for (i = p; i < e; i++) shadow_bits[i] = value;
          end
        end
        MODE_FIRST: begin
          ans.found_index = -13'sd1;
          if (p < 0) p += n;
          if (p < 0) p = 0;
          for (i = p; i < n && !hit; i++) begin
            if (shadow_bits[i] == value) begin
              ans.found_index = 13'(i);
              hit = 1'b1;
            end
          end
        end
        MODE_LAST: begin
          ans.found_index = -13'sd1;
          if (p < 0) p += n;
          if (p >= 0) begin
            if (p >= n) p = n - 1;
            for (i = p; i >= 0 && !hit; i--) begin
              if (shadow_bits[i] == value) begin
                ans.found_index = 13'(i);
                hit = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      answer_q.push_back(ans);
    endfunction

    // Compare one result word with the oldest queued answer
    function void check_result(logic flag, logic signed [12:0] found_index);
      answer_t exp;
      if (answer_q.size() == 0) begin
        $error("result word with nothing outstanding: flag=%0d found_index=%0d",
               flag, found_index);
        errors++;
        return;
      end
      exp = answer_q.pop_front();
      if (flag !== exp.flag) begin
        $error("flag: expected %0d, got %0d", exp.flag, flag);
        errors++;
      end
      if (found_index !== exp.found_index) begin
        $error("found_index: expected %0d, got %0d", exp.found_index, found_index);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_bitmap_get_set_fill_find.sv
// ----------------------------------------------------------------------------
// tb_bitmap_get_set_fill_find
// Drives get, set, fill and find commands into the bit-array store under
// several used lengths, with random sender gaps, and checks every result
// word against a shadow store kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_bitmap_get_set_fill_find;
  timeunit 1ns;
  timeprecision 1ps;

  import bgsff_pkg::*;
  import tb_bitmap_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int SEG_ITEMS   = 75;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         mode;
  logic signed [12:0] position;
  logic signed [13:0] end_position;
  logic               bit_value;
  logic               done;
  logic               flag;
  logic signed [12:0] found_index;
  logic               cfg_we;
  logic [9:0]         cfg_wdata;

  bitmap_scoreboard sb;
  int               idle_pct;
  int               stall_cycles;
  int               seg_lengths[12];

  bitmap_get_set_fill_find u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .position     (position),
    .end_position (end_position),
    .bit_value    (bit_value),
    .done         (done),
    .flag         (flag),
    .found_index  (found_index),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample handshakes on the edge: results first, then new commands
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(flag, found_index);
      if (start && !busy) sb.note_command(mode, position, end_position, bit_value);
      if (cfg_we) sb.note_length(cfg_wdata);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Idle the sender for a random number of cycles, then present one command
  // word and hold it until the block takes it
  task automatic send_cmd(input logic [2:0] op, input int pos, input int endp,
                          input logic value);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= op;
    position     <= pos[12:0];
    end_position <= endp[13:0];
    bit_value    <= value;
    do @(posedge clk); while (busy);
  endtask

  // Wait until every queued answer has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || sb.outstanding() != 0);
    @(posedge clk);
  endtask

  task automatic write_length(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[9:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random command, biased toward positions inside the used length
  task automatic random_cmd();
    int         n;
    int         r;
    int         pos;
    int         pw;
    int         endp;
    logic [2:0] op;
    n = sb.used_bits();
    r = $urandom_range(99);
    if (r < 18)      op = MODE_GET;
    else if (r < 36) op = MODE_SET;
    else if (r < 54) op = MODE_FILL;
    else if (r < 74) op = MODE_FIRST;
    else if (r < 94) op = MODE_LAST;
    else             op = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    r = $urandom_range(99);
    if (n > 0 && r < 60)      pos = $urandom_range(n - 1);
    else if (n > 0 && r < 80) pos = -int'($urandom_range(1, n));
    else                      pos = int'($urandom_range(8191)) - 4096;
    pw = (pos < 0) ? pos + n : pos;
    r = $urandom_range(99);
    if (r < 50)      endp = pw + int'($urandom_range(1, 200));
    else if (r < 65) endp = -int'($urandom_range(0, n));
    else if (r < 70) endp = n;
    else if (r < 75) endp = 4096;
    else             endp = int'($urandom_range(16383)) - 8192;
    send_cmd(op, pos, endp, 1'($urandom_range(1)));
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    mode         = MODE_GET;
    position     = '0;
    end_position = '0;
    bit_value    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    stall_cycles = 0;
    idle_pct     = 33;
    seg_lengths  = '{37, 1023, 8, 512, 0, 1, 700, 64, 513, 200, 1023, 512};
    seg_lengths[6] = $urandom_range(1, 1023);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: full length after reset
    send_cmd(MODE_GET,   0,     0,    1'b0);
    send_cmd(MODE_FIRST, 0,     0,    1'b0);
    send_cmd(MODE_FIRST, 0,     0,    1'b1);
    send_cmd(MODE_LAST,  4095,  0,    1'b1);
    send_cmd(MODE_SET,   0,     0,    1'b1);
    send_cmd(MODE_SET,   0,     0,    1'b1);
    send_cmd(MODE_SET,   -1,    0,    1'b1);
    send_cmd(MODE_GET,   4095,  0,    1'b0);
    send_cmd(MODE_GET,   -4096, 0,    1'b0);
    send_cmd(MODE_FILL,  100,   200,  1'b1);
    send_cmd(MODE_FIRST, 1,     0,    1'b1);
    send_cmd(MODE_LAST,  4094,  0,    1'b1);
    send_cmd(MODE_FILL,  -96,   8191, 1'b1);
    send_cmd(MODE_LAST,  -1,    0,    1'b0);
    send_cmd(MODE_FILL,  150,   -4000, 1'b0);
    send_cmd(MODE_FILL,  120,   -8192, 1'b0);
    send_cmd(MODE_LAST,  -4096, 0,    1'b1);
    send_cmd(MODE_RSVD5, 3,     5,    1'b1);
    send_cmd(MODE_RSVD7, -1,    -1,   1'b1);

    // Directed: one byte in use, then none
    write_length(1);
    send_cmd(MODE_SET,   100,   0,    1'b1);
    send_cmd(MODE_FIRST, -100,  0,    1'b1);
    send_cmd(MODE_LAST,  -100,  0,    1'b1);
    send_cmd(MODE_FILL,  0,     4096, 1'b0);
    write_length(0);
    send_cmd(MODE_GET,   0,     0,    1'b0);
    send_cmd(MODE_LAST,  0,     0,    1'b0);

    // Random segments: sender idles 33%, then 87%, then never
    for (int seg = 0; seg < 12; seg++) begin
      idle_pct = (seg < 4) ? 33 : (seg < 8) ? 87 : 0;
      write_length(seg_lengths[seg]);
      repeat (SEG_ITEMS) random_cmd();
    end

    drain();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
